// ===== src/tcfo_pkg.sv =====
// Package for the timecode frame offset adder: rate constants, pipeline layout and helpers.
package tcfo_pkg;

  localparam logic [1:0] CFG_FPS  = 2'd0;
  localparam logic [1:0] CFG_DROP = 2'd1;

  localparam logic [5:0] FPS_RESET = 6'd30;
  localparam logic [5:0] FPS_MAX   = 6'd60;

  localparam int unsigned FE_N      = 4;
  localparam int unsigned BE_MOD0   = 0;
  localparam int unsigned BE_FIX    = 8;
  localparam int unsigned BE_HR0    = 9;
  localparam int unsigned BE_TEN0   = 14;
  localparam int unsigned BE_DCSUB  = 17;
  localparam int unsigned BE_UNIT0  = 18;
  localparam int unsigned BE_DCADD  = 22;
  localparam int unsigned BE_SEC0   = 23;
  localparam int unsigned BE_N      = 29;
  localparam int unsigned LATENCY   = FE_N + BE_N;

  typedef struct packed {
    logic [5:0]  fps;
    logic [2:0]  dc;
    logic [11:0] fpm;
    logic [15:0] fp10;
    logic [17:0] fph;
    logic [22:0] day;
  } rate_t;

  typedef struct packed {
    logic [23:0] mag;
    logic        neg;
  } fe_t;

  typedef struct packed {
    logic [23:0] r;
    logic        neg;
    logic [4:0]  qh;
    logic [2:0]  qt;
    logic [3:0]  qu;
    logic [5:0]  om;
    logic [5:0]  qs;
    logic        lo;
    logic [22:0] sum;
  } be_t;

  function automatic rate_t rate_of(logic [5:0] fps_raw, logic drop);
    rate_t       rt;
    logic [5:0]  f;
    logic [2:0]  d;
    logic [11:0] f12;
    f = fps_raw;
    if (f == 6'd0) begin
      f = 6'd1;
    end else if (f > FPS_MAX) begin
      f = FPS_MAX;
    end
    if (!drop) begin
      d = 3'd0;
    end else if (f >= 6'd60) begin
      d = 3'd4;
    end else if (f >= 6'd45) begin
      d = 3'd3;
    end else if (f >= 6'd30) begin
      d = 3'd2;
    end else if (f >= 6'd15) begin
      d = 3'd1;
    end else begin
      d = 3'd0;
    end
    f12     = {6'd0, f};
    rt.fps  = f;
    rt.dc   = d;
    rt.fpm  = (f12 << 6) - (f12 << 2) - {9'd0, d};
    rt.fp10 = ({4'd0, rt.fpm} << 3) + ({4'd0, rt.fpm} << 1) + {13'd0, d};
    rt.fph  = ({2'd0, rt.fp10} << 2) + ({2'd0, rt.fp10} << 1);
    rt.day  = ({5'd0, rt.fph} << 4) + ({5'd0, rt.fph} << 3);
    return rt;
  endfunction

  // Remainder of a 6-bit frame label by the frame rate, one restoring step per bit.
  function automatic logic [5:0] frame_mod(logic [5:0] f, logic [5:0] fps);
    logic [11:0] r;
    logic [11:0] ds;
    r = {6'd0, f};
    for (int i = 5; i >= 0; i--) begin
      ds = {6'd0, fps} << i;
      if (r >= ds) begin
        r = r - ds;
      end
    end
    return r[5:0];
  endfunction

  // Returns {quotient bit, remainder} of one restoring step against d shifted by sh.
  function automatic logic [24:0] div_step(logic [23:0] r, logic [22:0] d, int unsigned sh);
    logic [30:0] ds;
    logic [30:0] rr;
    logic [24:0] res;
    ds = {8'd0, d} << sh;
    rr = {7'd0, r};
    if (rr >= ds) begin
      res = {1'b1, 24'(rr - ds)};
    end else begin
      res = {1'b0, r};
    end
    return res;
  endfunction

  // Splits minutes into {tens, units}.
  function automatic logic [6:0] min_split(logic [5:0] m);
    logic [2:0] t;
    logic [5:0] u;
    if (m >= 6'd50) begin
      t = 3'd5;
    end else if (m >= 6'd40) begin
      t = 3'd4;
    end else if (m >= 6'd30) begin
      t = 3'd3;
    end else if (m >= 6'd20) begin
      t = 3'd2;
    end else if (m >= 6'd10) begin
      t = 3'd1;
    end else begin
      t = 3'd0;
    end
    u = m - (({3'd0, t} << 3) + ({3'd0, t} << 1));
    return {t, u[3:0]};
  endfunction

endpackage

// ===== src/tcfo_front.sv =====
// Front end: normalises the timecode, converts it to a frame count and adds the offset.
module tcfo_front (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 vld_in,
  input  logic [4:0]           hours,
  input  logic [5:0]           minutes,
  input  logic [5:0]           seconds,
  input  logic [5:0]           frames,
  input  logic signed [23:0]   offset,
  input  tcfo_pkg::rate_t      rate,
  input  logic                 drop,
  output logic                 vld_out,
  output tcfo_pkg::fe_t        fe
);

  logic                v1_r, v2_r, v3_r, v4_r;
  logic [4:0]          h1_r, h2_r;
  logic [5:0]          m1_r;
  logic [6:0]          s1_r;
  logic [5:0]          f1_r, f2_r, f3_r;
  logic signed [23:0]  off1_r, off2_r, off3_r;
  logic [3:0]          mu2_r;
  logic [2:0]          mt2_r;
  logic [5:0]          s2_r;
  logic [22:0]         ph3_r;
  logic [15:0]         pu3_r;
  logic [18:0]         pt3_r;
  logic [11:0]         ps3_r;
  tcfo_pkg::fe_t       fe4_r;

  logic                fc;
  logic [5:0]          f1_nxt;
  logic [5:0]          s2_nxt, f2_nxt;
  logic [6:0]          mm;
  logic [5:0]          m2;
  logic [5:0]          hh;
  logic [4:0]          h2_nxt;
  logic [6:0]          msp;
  logic [23:0]         tot;
  logic signed [25:0]  v;
  logic [25:0]         av;
  tcfo_pkg::fe_t       fe4_nxt;

  always_comb begin
    fc     = (frames >= rate.fps);
    f1_nxt = fc ? tcfo_pkg::frame_mod(frames, rate.fps) : frames;
  end

  always_comb begin
    logic mc, hc;
    mc = (s1_r > 7'd59);
    s2_nxt = mc ? 6'(s1_r - 7'd60) : s1_r[5:0];
    mm = {1'b0, m1_r} + {6'd0, mc};
    hc = (mm > 7'd59);
    m2 = hc ? 6'(mm - 7'd60) : mm[5:0];
    hh = {1'b0, h1_r} + {5'd0, hc};
    h2_nxt = (hh > 6'd23) ? 5'(hh - 6'd24) : hh[4:0];
    msp = tcfo_pkg::min_split(m2);
    f2_nxt = (drop && f1_r == 6'd0 && s2_nxt == 6'd0 && msp[3:0] != 4'd0) ? 6'd2 : f1_r;
  end

  always_comb begin
    tot = {1'b0, ph3_r} + {8'd0, pu3_r} + {5'd0, pt3_r} + {12'd0, ps3_r} + {18'd0, f3_r};
    v   = $signed({2'b00, tot}) + 26'(off3_r);
    av  = v[25] ? 26'(-v) : 26'(v);
    fe4_nxt.mag = av[23:0];
    fe4_nxt.neg = v[25];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else begin
      v1_r <= vld_in;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
    end
  end

  always_ff @(posedge clk) begin
    h1_r   <= hours;
    m1_r   <= minutes;
    s1_r   <= {1'b0, seconds} + {6'd0, fc};
    f1_r   <= f1_nxt;
    off1_r <= offset;
    h2_r   <= h2_nxt;
    mt2_r  <= msp[6:4];
    mu2_r  <= msp[3:0];
    s2_r   <= s2_nxt;
    f2_r   <= f2_nxt;
    off2_r <= off1_r;
    ph3_r  <= 23'({18'd0, h2_r} * {5'd0, rate.fph});
    pu3_r  <= 16'({12'd0, mu2_r} * {4'd0, rate.fpm});
    pt3_r  <= 19'({16'd0, mt2_r} * {3'd0, rate.fp10});
    ps3_r  <= 12'({6'd0, s2_r} * {6'd0, rate.fps});
    f3_r   <= f2_r;
    off3_r <= off2_r;
    fe4_r  <= fe4_nxt;
  end

  assign vld_out = v4_r;
  assign fe      = fe4_r;

endmodule

// ===== src/timecode_frame_offset_adder_unit.sv =====
// Top level of the timecode frame offset adder: configuration, pipelined back conversion.
//
//  Channel  Ports                                          Transfer when
//  input    start, busy, in_hours..in_offset_frames        start high, busy low
//  result   out_valid, out_hours..out_total_frames         out_valid high
//  config   cfg_we, cfg_index, cfg_wdata                   cfg_we high
//
// One item enters every cycle; busy is always low. Each item passes four front-end stages,
// then 29 back-end stages: restoring division steps, one quotient bit per step, against
// the registered day, hour, ten-minute, minute and second lengths, a sign fix-up and the
// drop-frame subtract and add. Reset acts only on the valid bits and config. No stall.
module timecode_frame_offset_adder_unit (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic [4:0]         in_hours,
  input  logic [5:0]         in_minutes,
  input  logic [5:0]         in_seconds,
  input  logic [5:0]         in_frames,
  input  logic signed [23:0] in_offset_frames,
  output logic               out_valid,
  output logic [4:0]         out_hours,
  output logic [5:0]         out_minutes,
  output logic [5:0]         out_seconds,
  output logic [5:0]         out_frames,
  output logic [22:0]        out_total_frames,
  input  logic               cfg_we,
  input  logic [1:0]         cfg_index,
  input  logic [5:0]         cfg_wdata
);

  logic [5:0]       fps_r, fps_nxt;
  logic             drop_r, drop_nxt;
  tcfo_pkg::rate_t  rate_r;
  logic             fe_vld;
  tcfo_pkg::fe_t    fe;
  tcfo_pkg::be_t    be_r [tcfo_pkg::BE_N];
  logic             vld_r [tcfo_pkg::BE_N];

  always_comb begin
    fps_nxt  = fps_r;
    drop_nxt = drop_r;
    if (cfg_we) begin
      case (cfg_index)
        tcfo_pkg::CFG_FPS:  fps_nxt  = cfg_wdata;
        tcfo_pkg::CFG_DROP: drop_nxt = cfg_wdata[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fps_r  <= tcfo_pkg::FPS_RESET;
      drop_r <= 1'b0;
      rate_r <= tcfo_pkg::rate_of(tcfo_pkg::FPS_RESET, 1'b0);
    end else begin
      fps_r  <= fps_nxt;
      drop_r <= drop_nxt;
      rate_r <= tcfo_pkg::rate_of(fps_nxt, drop_nxt);
    end
  end

  assign busy = 1'b0;

  tcfo_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .vld_in  (start && !busy),
    .hours   (in_hours),
    .minutes (in_minutes),
    .seconds (in_seconds),
    .frames  (in_frames),
    .offset  (in_offset_frames),
    .rate    (rate_r),
    .drop    (drop_r),
    .vld_out (fe_vld),
    .fe      (fe)
  );

  for (genvar j = 0; j < tcfo_pkg::BE_N; j++) begin : g_be
    tcfo_pkg::be_t src;
    tcfo_pkg::be_t be_nxt;
    logic          v_src;

    if (j == 0) begin : g_first
      always_comb begin
        src     = '0;
        src.r   = fe.mag;
        src.neg = fe.neg;
        v_src   = fe_vld;
      end
    end else begin : g_next
      assign src   = be_r[j-1];
      assign v_src = vld_r[j-1];
    end

    always_comb begin
      logic [24:0] t;
      t      = '0;
      be_nxt = src;
      if (j < tcfo_pkg::BE_FIX) begin
        t = tcfo_pkg::div_step(src.r, rate_r.day, tcfo_pkg::BE_FIX - 1 - j);
        be_nxt.r = t[23:0];
      end else if (j == tcfo_pkg::BE_FIX) begin
        if (src.neg && src.r != 24'd0) begin
          be_nxt.r = {1'b0, rate_r.day} - src.r;
        end
        be_nxt.sum = be_nxt.r[22:0];
      end else if (j < tcfo_pkg::BE_TEN0) begin
        t = tcfo_pkg::div_step(src.r, {5'd0, rate_r.fph}, tcfo_pkg::BE_TEN0 - 1 - j);
        be_nxt.r = t[23:0];
        be_nxt.qh[tcfo_pkg::BE_TEN0 - 1 - j] = t[24];
      end else if (j < tcfo_pkg::BE_DCSUB) begin
        t = tcfo_pkg::div_step(src.r, {7'd0, rate_r.fp10}, tcfo_pkg::BE_DCSUB - 1 - j);
        be_nxt.r = t[23:0];
        be_nxt.qt[tcfo_pkg::BE_DCSUB - 1 - j] = t[24];
      end else if (j == tcfo_pkg::BE_DCSUB) begin
        be_nxt.lo = (src.r < {21'd0, rate_r.dc});
        if (!be_nxt.lo) begin
          be_nxt.r = src.r - {21'd0, rate_r.dc};
        end
      end else if (j < tcfo_pkg::BE_DCADD) begin
        t = tcfo_pkg::div_step(src.r, {11'd0, rate_r.fpm}, tcfo_pkg::BE_DCADD - 1 - j);
        be_nxt.r = t[23:0];
        be_nxt.qu[tcfo_pkg::BE_DCADD - 1 - j] = t[24];
      end else if (j == tcfo_pkg::BE_DCADD) begin
        if (!src.lo) begin
          be_nxt.r = src.r + {21'd0, rate_r.dc};
        end
        be_nxt.om = (({3'd0, src.qt} << 3) + ({3'd0, src.qt} << 1)) + {2'd0, src.qu};
      end else begin
        t = tcfo_pkg::div_step(src.r, {17'd0, rate_r.fps}, tcfo_pkg::BE_N - 1 - j);
        be_nxt.r = t[23:0];
        be_nxt.qs[tcfo_pkg::BE_N - 1 - j] = t[24];
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[j] <= 1'b0;
      end else begin
        vld_r[j] <= v_src;
      end
    end

    always_ff @(posedge clk) begin
      be_r[j] <= be_nxt;
    end
  end

  assign out_valid        = vld_r[tcfo_pkg::BE_N-1];
  assign out_hours        = be_r[tcfo_pkg::BE_N-1].qh;
  assign out_minutes      = be_r[tcfo_pkg::BE_N-1].om;
  assign out_seconds      = be_r[tcfo_pkg::BE_N-1].qs;
  assign out_frames       = be_r[tcfo_pkg::BE_N-1].r[5:0];
  assign out_total_frames = be_r[tcfo_pkg::BE_N-1].sum;

  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |-> ##(tcfo_pkg::LATENCY) out_valid)
    else $error("accepted item did not produce a result on time");

  a_fields: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_hours <= 5'd23 && out_minutes <= 6'd59 && out_seconds <= 6'd59))
    else $error("result timecode out of range");

  a_day: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_total_frames < rate_r.day))
    else $error("frame count not below the day length");

  a_frames: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_frames < rate_r.fps))
    else $error("frame label not below the frame rate");

endmodule

// ===== tb/timecode_frame_offset_adder_unit_tb.sv =====
// Self-checking testbench for the timecode frame offset adder: predicted results against the pipeline.
`timescale 1ns / 1ps

module timecode_frame_offset_adder_unit_tb;

  typedef struct {
    logic [4:0]  hours;
    logic [5:0]  minutes;
    logic [5:0]  seconds;
    logic [5:0]  frames;
    logic [22:0] total;
  } timecode_t;

  class timecode_scoreboard;
    timecode_t   pending[$];
    logic [5:0]  fps_reg;
    logic        drop_reg;
    int          mismatches;

    function new();
      fps_reg = tcfo_pkg::FPS_RESET;
      drop_reg = 1'b0;
      mismatches = 0;
    endfunction

    function void note_input(logic [4:0] h_in, logic [5:0] m_in, logic [5:0] s_in,
                             logic [5:0] f_in, logic signed [23:0] off_in);
      longint fps, dc, fpm, fp10, fph, day_len, h, m, s, f, off, total, r, ten, unit, om;
      timecode_t tc;
      fps = fps_reg;
      if (fps < 1) fps = 1;
      if (fps > 60) fps = 60;
      dc = drop_reg ? fps / 15 : 0;
      fpm = 60 * fps - dc;
      fp10 = fpm * 10 + dc;
      fph = fp10 * 6;
      day_len = fph * 24;
      h = h_in;
      m = m_in;
      s = s_in;
      f = f_in;
      off = off_in;
      if (f >= fps) begin
        f = f % fps;
        s++;
      end
      if (s > 59) begin
        s = s % 60;
        m++;
      end
      if (m > 59) begin
        m = m % 60;
        h++;
      end
      if (h > 23) h = h % 24;
      if (drop_reg && f == 0 && s == 0 && (m % 10) != 0) f += 2;
      total = h * fph + (m % 10) * fpm + (m / 10) * fp10 + s * fps + f;
      r = (total + off) % day_len;
      if (r < 0) r += day_len;
      tc.total = 23'(r);
      tc.hours = 5'(r / fph);
      r = r % fph;
      if (drop_reg) begin
        ten = r / fp10;
        r = r % fp10 - dc;
        unit = r / fpm;
        r = r % fpm;
        om = ten * 10 + unit;
        r += dc;
      end else begin
        om = r / fpm;
        r = r % fpm;
      end
      tc.minutes = 6'(om);
      tc.seconds = 6'(r / fps);
      tc.frames = 6'(r % fps);
      pending.push_back(tc);
    endfunction

    function void check_result(timecode_t got);
      timecode_t exp_tc;
      if (pending.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("Unexpected result transfer %0d:%0d:%0d:%0d total %0d",
                                       got.hours, got.minutes, got.seconds, got.frames, got.total);
        return;
      end
      exp_tc = pending.pop_front();
      if (got.hours !== exp_tc.hours || got.minutes !== exp_tc.minutes ||
          got.seconds !== exp_tc.seconds || got.frames !== exp_tc.frames ||
          got.total !== exp_tc.total) begin
        mismatches++;
        if (mismatches <= 10)
          $display("Mismatch: expected %0d:%0d:%0d:%0d total %0d, got %0d:%0d:%0d:%0d total %0d",
                   exp_tc.hours, exp_tc.minutes, exp_tc.seconds, exp_tc.frames, exp_tc.total,
                   got.hours, got.minutes, got.seconds, got.frames, got.total);
      end
    endfunction
  endclass

  logic               clk;
  logic               rst_n;
  logic               start;
  logic               busy;
  logic [4:0]         in_hours;
  logic [5:0]         in_minutes;
  logic [5:0]         in_seconds;
  logic [5:0]         in_frames;
  logic signed [23:0] in_offset_frames;
  logic               out_valid;
  logic [4:0]         out_hours;
  logic [5:0]         out_minutes;
  logic [5:0]         out_seconds;
  logic [5:0]         out_frames;
  logic [22:0]        out_total_frames;
  logic               cfg_we;
  logic [1:0]         cfg_index;
  logic [5:0]         cfg_wdata;

  timecode_scoreboard sb;
  int idle_pct;
  int quiet_cycles = 0;

  timecode_frame_offset_adder_unit u_dut (.*);

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  always @(posedge clk) begin
    timecode_t got;
    if (rst_n) begin
      if (out_valid) begin
        got.hours = out_hours;
        got.minutes = out_minutes;
        got.seconds = out_seconds;
        got.frames = out_frames;
        got.total = out_total_frames;
        sb.check_result(got);
      end
      if ((start && !busy) || out_valid) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
    end
  end

  always @(posedge clk) begin
    if (quiet_cycles >= 5000) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  task automatic write_cfg(logic [1:0] idx, logic [5:0] val);
    @(negedge clk);
    cfg_we = 1'b1;
    cfg_index = idx;
    cfg_wdata = val;
    @(negedge clk);
    cfg_we = 1'b0;
    if (idx == tcfo_pkg::CFG_FPS) sb.fps_reg = val;
    else if (idx == tcfo_pkg::CFG_DROP) sb.drop_reg = val[0];
  endtask

  task automatic send_timecode(logic [4:0] h, logic [5:0] m, logic [5:0] s, logic [5:0] f,
                               logic signed [23:0] off);
    while (idle_pct > 0 && $urandom_range(99, 0) < idle_pct) begin
      start = 1'b0;
      @(negedge clk);
    end
    start = 1'b1;
    in_hours = h;
    in_minutes = m;
    in_seconds = s;
    in_frames = f;
    in_offset_frames = off;
    @(posedge clk);
    while (busy) @(posedge clk);
    sb.note_input(h, m, s, f, off);
    @(negedge clk);
    start = 1'b0;
  endtask

  task automatic drain();
    while (sb.pending.size() != 0) @(negedge clk);
    repeat (tcfo_pkg::LATENCY + 4) @(negedge clk);
  endtask

  task automatic random_timecodes(int count);
    logic signed [23:0] off;
    for (int i = 0; i < count; i++) begin
      case ($urandom_range(3, 0))
        0: off = $signed(24'($urandom));
        1: off = $signed(24'($urandom_range(10368000, 0))) - 24'sd5184000;
        default: off = $signed(24'($urandom_range(2000, 0))) - 24'sd1000;
      endcase
      if ($urandom_range(9, 0) == 0)
        send_timecode(5'($urandom), 6'($urandom), 6'($urandom), 6'($urandom), off);
      else if ($urandom_range(4, 0) == 0)
        send_timecode(5'($urandom_range(23, 0)), 6'($urandom_range(59, 0)), 6'd0,
                      6'($urandom_range(1, 0)), off);
      else
        send_timecode(5'($urandom_range(23, 0)), 6'($urandom_range(59, 0)),
                      6'($urandom_range(59, 0)), 6'($urandom_range(59, 0)), off);
    end
  endtask

  initial begin
    sb = new();
    idle_pct = 0;
    rst_n = 1'b0;
    start = 1'b0;
    in_hours = '0;
    in_minutes = '0;
    in_seconds = '0;
    in_frames = '0;
    in_offset_frames = '0;
    cfg_we = 1'b0;
    cfg_index = tcfo_pkg::CFG_FPS;
    cfg_wdata = '0;
    repeat (5) @(negedge clk);
    rst_n = 1'b1;

    send_timecode(5'd0, 6'd0, 6'd0, 6'd0, 24'sd0);
    send_timecode(5'd23, 6'd59, 6'd59, 6'd29, 24'sd1);
    send_timecode(5'd31, 6'd63, 6'd63, 6'd63, 24'sd5184000);
    send_timecode(5'd12, 6'd30, 6'd0, 6'd0, -24'sd5184000);
    send_timecode(5'd0, 6'd0, 6'd0, 6'd0, -24'sd1);
    send_timecode(5'd1, 6'd2, 6'd3, 6'd4, 24'sh7FFFFF);
    send_timecode(5'd1, 6'd2, 6'd3, 6'd4, 24'sh800000);
    drain();
    write_cfg(tcfo_pkg::CFG_DROP, 6'd1);
    send_timecode(5'd0, 6'd1, 6'd0, 6'd0, 24'sd0);
    send_timecode(5'd0, 6'd10, 6'd0, 6'd0, 24'sd0);
    send_timecode(5'd0, 6'd0, 6'd59, 6'd29, 24'sd1);
    send_timecode(5'd0, 6'd9, 6'd59, 6'd29, 24'sd1);
    send_timecode(5'd23, 6'd59, 6'd59, 6'd29, 24'sd1);
    send_timecode(5'd10, 6'd10, 6'd10, 6'd10, -24'sd5184000);
    drain();
    write_cfg(tcfo_pkg::CFG_FPS, 6'd0);
    send_timecode(5'd0, 6'd1, 6'd0, 6'd0, 24'sd100);
    send_timecode(5'd23, 6'd59, 6'd59, 6'd5, -24'sd3);
    drain();
    write_cfg(tcfo_pkg::CFG_FPS, 6'd63);
    send_timecode(5'd0, 6'd19, 6'd0, 6'd1, 24'sd0);
    send_timecode(5'd23, 6'd59, 6'd59, 6'd59, 24'sd1);
    drain();
    write_cfg(2'd3, 6'd5);
    write_cfg(2'd2, 6'd7);
    send_timecode(5'd2, 6'd22, 6'd0, 6'd0, 24'sd0);
    drain();

    for (int phase = 0; phase < 16; phase++) begin
      case (phase % 4)
        0: idle_pct = 0;
        1: idle_pct = 46;
        2: idle_pct = 31;
        default: idle_pct = 46;
      endcase
      case (phase % 5)
        0: write_cfg(tcfo_pkg::CFG_FPS, 6'd30);
        1: write_cfg(tcfo_pkg::CFG_FPS, 6'd60);
        2: write_cfg(tcfo_pkg::CFG_FPS, 6'd1);
        3: write_cfg(tcfo_pkg::CFG_FPS, 6'($urandom_range(63, 0)));
        default: write_cfg(tcfo_pkg::CFG_FPS, 6'($urandom_range(29, 14)));
      endcase
      write_cfg(tcfo_pkg::CFG_DROP, 6'($urandom));
      random_timecodes(53);
      drain();
    end

    if (sb.mismatches == 0 && sb.pending.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

// ===== timecode_frame_offset_adder_unit.f =====
src/tcfo_pkg.sv
src/tcfo_front.sv
src/timecode_frame_offset_adder_unit.sv
tb/timecode_frame_offset_adder_unit_tb.sv
